// ----- design/fqgd_pkg.sv -----
// Shared types, constants and helper functions of the FM gray demodulator.
`timescale 1ns / 1ps
package fqgd_pkg;

    // Boxcar length, kept a power of two so the average is a shift
    localparam int FILTER_SHIFT = 4;
    localparam int FILTER_TAPS  = 1 << FILTER_SHIFT;

    localparam int TRIG_TABLE_BITS_DEF = 10;
    localparam int CORDIC_STAGES_DEF   = 16;
    localparam int ATAN_ENTRIES        = 24;

    localparam int CORDIC_W = 34;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    // Register reset values
    localparam logic [31:0] PHASE_STEP_RST = 32'd740175771;
    localparam logic [15:0] GRAY_GAIN_RST  = 16'd7028;
    localparam logic [31:0] CLIP_LEVEL_RST = 32'd655;

    // Register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAY_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEVEL = 2'd2;

    // Gray mapping offset, 127.5 in Q16
    localparam logic signed [63:0] GRAY_OFFSET = 64'sd8355840;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROT,
        S_MIX_I,
        S_MIX_Q,
        S_FILT,
        S_SQ_I,
        S_SQ_Q,
        S_DOT_A,
        S_DOT_B,
        S_CRS_A,
        S_CRS_B,
        S_NORM,
        S_VEC,
        S_GAIN,
        S_DONE
    } t_state;

    // Arctangent of 2^-k in 2^-32 turn
    function automatic logic [29:0] atan_turn(input logic [4:0] k);
        logic [29:0] v;
        case (k)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10679838;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41722;
            5'd15:   v = 30'd20861;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2608;
            5'd19:   v = 30'd1304;
            5'd20:   v = 30'd652;
            5'd21:   v = 30'd326;
            5'd22:   v = 30'd163;
            5'd23:   v = 30'd81;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // Q30 to Q1.15 with round half up and saturation
    function automatic logic signed [15:0] to_q15(input logic signed [CORDIC_W-1:0] v);
        logic signed [CORDIC_W-1:0] t;
        logic signed [15:0] r;
        t = (v + 34'sd16384) >>> 15;
        if (t > 34'sd32767) begin
            r = 16'sh7FFF;
        end else if (t < -34'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = t[15:0];
        end
        return r;
    endfunction

endpackage

// ----- design/fqgd_if.sv -----
// Handshake channels of the demodulator: sample input, gray output, register writes.
`timescale 1ns / 1ps
interface fqgd_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               block_last;
    modport source (output valid, output sample, output block_last, input ready);
    modport sink   (input valid, input sample, input block_last, output ready);
endinterface

interface fqgd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] gray;
    logic       weak_res;
    logic       out_last;
    modport source (output valid, output gray, output weak_res, output out_last, input ready);
    modport sink   (input valid, input gray, input weak_res, input out_last, output ready);
endinterface

interface fqgd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/fqgd_mul.sv -----
// Digit-serial signed 32x32 multiplier, four multiplier bits per cycle.
`timescale 1ns / 1ps
module fqgd_mul
    import fqgd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic               o_done,
    output logic signed [63:0] o_prod
);

    logic        r_busy, n_busy;
    logic [2:0]  r_cnt;
    logic        r_done;
    logic [31:0] r_mag_a;
    logic [31:0] r_mb;
    logic [63:0] r_acc;
    logic        r_neg;
    logic [35:0] w_part;
    logic [35:0] w_sum;

    // one digit of the multiplier per cycle into the top of the accumulator
    assign w_part = r_mag_a * r_mb[3:0];
    assign w_sum  = {4'b0, r_acc[63:32]} + w_part;
    assign n_busy = r_busy && (r_cnt != 3'd7);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 3'd0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 3'd0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= r_cnt + 3'd1;
            r_done <= r_busy && (r_cnt == 3'd7);
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag_a <= i_a[31] ? (32'd0 - i_a) : i_a;
            r_mb    <= i_b[31] ? (32'd0 - i_b) : i_b;
            r_neg   <= i_a[31] ^ i_b[31];
            r_acc   <= 64'd0;
        end else if (r_busy) begin
            r_acc <= {w_sum, r_acc[31:4]};
            r_mb  <= r_mb >> 4;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_neg ? -$signed(r_acc) : $signed(r_acc);

endmodule

// ----- design/fm_quadrature_gray_demodulator_unit.sv -----
// FM quadrature demodulator producing one gray level per audio sample.
// Each sample runs a rotation CORDIC over the ATAN_ENTRIES table angles for the
// carrier, nine products of a digit-serial multiplier, a prescaling of the product
// vector, a phase CORDIC over CORDIC_STAGES angles and the control states; weak
// samples skip the phase part.
// The shared multiplier and the single CORDIC datapath set the sample time. One
// sample is in work at a time; the next is accepted once the result is stored
// in the output register, and register writes are taken at any time.
`timescale 1ns / 1ps
module fm_quadrature_gray_demodulator_unit
    import fqgd_pkg::*;
#(
    parameter int TRIG_TABLE_BITS = TRIG_TABLE_BITS_DEF,
    parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fqgd_in_if.sink     i_in,
    fqgd_out_if.source  o_out,
    fqgd_cfg_if.sink    i_cfg
);

    localparam int SUM_W = 32 + FILTER_SHIFT;

    // configuration
    logic [31:0] r_phase_step;
    logic [15:0] r_gray_gain;
    logic [31:0] r_clip;

    // state of the filter and oscillator
    t_state r_state, n_state;
    logic [31:0]              r_nco;
    logic signed [31:0]       r_ihist [FILTER_TAPS];
    logic signed [31:0]       r_qhist [FILTER_TAPS];
    logic [FILTER_SHIFT-1:0]  r_ptr;
    logic signed [SUM_W-1:0]  r_isum, r_qsum;
    logic signed [31:0]       r_prev_i, r_prev_q;
    logic [49:0]              r_prv_sq;

    // per-sample work registers
    logic signed [15:0]       r_sample;
    logic                     r_last;
    logic [1:0]               r_quad;
    logic signed [15:0]       r_c, r_s;
    logic signed [31:0]       r_mi, r_mq;
    logic signed [63:0]       r_acc, r_re, r_im;
    logic [49:0]              r_cur_sq;
    logic                     r_weak;
    logic signed [17:0]       r_step;
    logic signed [CORDIC_W-1:0] r_x, r_y, r_z;
    logic [4:0]               r_k;
    logic                     r_issued;

    // output register
    logic       r_out_valid;
    logic [7:0] r_gray;
    logic       r_out_weak;
    logic       r_out_last;

    // multiplier
    logic               w_mul_start;
    logic signed [31:0] w_mul_a, w_mul_b;
    logic               w_mul_done;
    logic signed [63:0] w_prod;
    logic               w_mul_state;

    fqgd_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    // filtered values, division truncated toward zero
    logic signed [SUM_W-1:0] w_isum_adj, w_qsum_adj;
    logic signed [31:0]      w_fi, w_fq;
    assign w_isum_adj = r_isum + (r_isum[SUM_W-1] ? SUM_W'(FILTER_TAPS - 1) : '0);
    assign w_qsum_adj = r_qsum + (r_qsum[SUM_W-1] ? SUM_W'(FILTER_TAPS - 1) : '0);
    assign w_fi = 32'(w_isum_adj >>> FILTER_SHIFT);
    assign w_fq = 32'(w_qsum_adj >>> FILTER_SHIFT);

    // squared magnitude and weak decision
    logic [63:0] w_sq_sum;
    logic [49:0] w_cur_sq;
    logic        w_weak;
    assign w_sq_sum = r_acc + w_prod;
    assign w_cur_sq = w_sq_sum[63:14];
    assign w_weak   = (w_cur_sq <= {18'd0, r_clip}) && (r_prv_sq <= {18'd0, r_clip});

    // shared CORDIC step
    logic                       w_rot;
    logic                       w_dir;
    logic signed [CORDIC_W-1:0] w_xs, w_ys, w_at, n_x, n_y, n_z;
    logic                       w_rot_last, w_vec_last;
    assign w_rot = (r_state == S_ROT);
    assign w_dir = w_rot ? !r_z[CORDIC_W-1] : r_y[CORDIC_W-1];
    assign w_xs  = r_x >>> r_k;
    assign w_ys  = r_y >>> r_k;
    assign w_at  = {4'b0, atan_turn(r_k)};
    assign n_x   = w_dir ? (r_x - w_ys) : (r_x + w_ys);
    assign n_y   = w_dir ? (r_y + w_xs) : (r_y - w_xs);
    assign n_z   = w_dir ? (r_z - w_at) : (r_z + w_at);
    assign w_rot_last = (r_k == 5'(ATAN_ENTRIES - 1));
    assign w_vec_last = (r_k == 5'(CORDIC_STAGES - 1));

    // carrier from the rotated vector by quadrant
    logic signed [15:0] w_c, w_s;
    always_comb begin
        case (r_quad)
            2'd0: begin
                w_c = to_q15(n_x);
                w_s = to_q15(n_y);
            end
            2'd1: begin
                w_c = to_q15(-n_y);
                w_s = to_q15(n_x);
            end
            2'd2: begin
                w_c = to_q15(-n_x);
                w_s = to_q15(-n_y);
            end
            default: begin
                w_c = to_q15(n_y);
                w_s = to_q15(-n_x);
            end
        endcase
    end

    // phase angle truncated to the table resolution
    logic [31:0] w_ang;
    assign w_ang = r_nco & ~((32'd1 << (32 - TRIG_TABLE_BITS)) - 32'd1);

    // prescale test of the product vector
    logic w_zero, w_fits;
    logic signed [CORDIC_W-1:0] w_re_c, w_im_c;
    assign w_zero = (r_re == 64'sd0) && (r_im == 64'sd0);
    assign w_fits = ((r_re[63:30] == '0) || (r_re[63:30] == '1)) &&
                    ((r_im[63:30] == '0) || (r_im[63:30] == '1));
    assign w_re_c = r_re[CORDIC_W-1:0];
    assign w_im_c = r_im[CORDIC_W-1:0];

    // gray mapping
    logic signed [63:0] w_n, w_nr;
    logic [7:0]         w_gray;
    assign w_n  = GRAY_OFFSET - r_acc;
    assign w_nr = (w_n + 64'sd32768) >>> 16;
    always_comb begin
        if (r_weak) begin
            w_gray = 8'hFF;
        end else if (w_n < 64'sd0) begin
            w_gray = 8'h00;
        end else if (w_nr > 64'sd255) begin
            w_gray = 8'hFF;
        end else begin
            w_gray = w_nr[7:0];
        end
    end

    logic w_in_fire, w_out_free;
    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_in_fire) n_state = S_ROT;
            S_ROT:   if (w_rot_last) n_state = S_MIX_I;
            S_MIX_I: if (w_mul_done) n_state = S_MIX_Q;
            S_MIX_Q: if (w_mul_done) n_state = S_FILT;
            S_FILT:  n_state = S_SQ_I;
            S_SQ_I:  if (w_mul_done) n_state = S_SQ_Q;
            S_SQ_Q:  if (w_mul_done) n_state = w_weak ? S_DONE : S_DOT_A;
            S_DOT_A: if (w_mul_done) n_state = S_DOT_B;
            S_DOT_B: if (w_mul_done) n_state = S_CRS_A;
            S_CRS_A: if (w_mul_done) n_state = S_CRS_B;
            S_CRS_B: if (w_mul_done) n_state = S_NORM;
            S_NORM: begin
                if (w_zero) n_state = S_GAIN;
                else if (w_fits) n_state = S_VEC;
            end
            S_VEC:   if (w_vec_last) n_state = S_GAIN;
            S_GAIN:  if (w_mul_done) n_state = S_DONE;
            S_DONE:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer: multiplier operands and start
    always_comb begin
        w_mul_state = 1'b1;
        w_mul_a     = w_fi;
        w_mul_b     = w_fi;
        case (r_state)
            S_MIX_I: begin
                w_mul_a = 32'(r_sample);
                w_mul_b = 32'(r_c);
            end
            S_MIX_Q: begin
                w_mul_a = 32'(r_sample);
                w_mul_b = 32'(r_s);
            end
            S_SQ_I: begin
                w_mul_a = w_fi;
                w_mul_b = w_fi;
            end
            S_SQ_Q: begin
                w_mul_a = w_fq;
                w_mul_b = w_fq;
            end
            S_DOT_A: begin
                w_mul_a = r_prev_i;
                w_mul_b = w_fi;
            end
            S_DOT_B: begin
                w_mul_a = r_prev_q;
                w_mul_b = w_fq;
            end
            S_CRS_A: begin
                w_mul_a = r_prev_i;
                w_mul_b = w_fq;
            end
            S_CRS_B: begin
                w_mul_a = r_prev_q;
                w_mul_b = w_fi;
            end
            S_GAIN: begin
                w_mul_a = {16'd0, r_gray_gain};
                w_mul_b = 32'(r_step);
            end
            default: w_mul_state = 1'b0;
        endcase
    end
    assign w_mul_start = w_mul_state && !r_issued;
    assign i_in.ready  = (r_state == S_IDLE);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_mul_start) begin
                r_issued <= 1'b1;
            end else if (w_mul_done) begin
                r_issued <= 1'b0;
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // configuration writes
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= PHASE_STEP_RST;
            r_gray_gain  <= GRAY_GAIN_RST;
            r_clip       <= CLIP_LEVEL_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_PHASE_STEP: r_phase_step <= i_cfg.data;
                CFG_GRAY_GAIN:  r_gray_gain  <= i_cfg.data[15:0];
                CFG_CLIP_LEVEL: r_clip       <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // filter and oscillator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nco    <= '0;
            r_ptr    <= '0;
            r_isum   <= '0;
            r_qsum   <= '0;
            r_prev_i <= '0;
            r_prev_q <= '0;
            r_prv_sq <= '0;
            for (int t = 0; t < FILTER_TAPS; t++) begin
                r_ihist[t] <= '0;
                r_qhist[t] <= '0;
            end
        end else begin
            if (w_in_fire) begin
                r_nco <= r_nco + r_phase_step;
            end
            if (r_state == S_FILT) begin
                r_isum <= r_isum + SUM_W'(r_mi) - SUM_W'(r_ihist[r_ptr]);
                r_qsum <= r_qsum + SUM_W'(r_mq) - SUM_W'(r_qhist[r_ptr]);
                r_ihist[r_ptr] <= r_mi;
                r_qhist[r_ptr] <= r_mq;
                r_ptr <= r_ptr + 1'b1;
            end
            if (r_state == S_DONE && w_out_free) begin
                r_prev_i <= w_fi;
                r_prev_q <= w_fq;
                r_prv_sq <= r_cur_sq;
            end
        end
    end

    // per-sample datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    r_sample <= i_in.sample;
                    r_last   <= i_in.block_last;
                    r_quad   <= w_ang[31:30];
                    r_x      <= CORDIC_GAIN_Q30;
                    r_y      <= '0;
                    r_z      <= {4'b0, w_ang[29:0]};
                    r_k      <= '0;
                end
            end
            S_ROT: begin
                r_x <= n_x;
                r_y <= n_y;
                r_z <= n_z;
                r_k <= r_k + 5'd1;
                if (w_rot_last) begin
                    r_c <= w_c;
                    r_s <= w_s;
                end
            end
            S_MIX_I: if (w_mul_done) r_mi <= w_prod[31:0];
            S_MIX_Q: if (w_mul_done) r_mq <= w_prod[31:0];
            S_SQ_I:  if (w_mul_done) r_acc <= w_prod;
            S_SQ_Q: begin
                if (w_mul_done) begin
                    r_cur_sq <= w_cur_sq;
                    r_weak   <= w_weak;
                end
            end
            S_DOT_A: if (w_mul_done) r_acc <= w_prod;
            S_DOT_B: if (w_mul_done) r_re <= r_acc + w_prod;
            S_CRS_A: if (w_mul_done) r_acc <= w_prod;
            S_CRS_B: if (w_mul_done) r_im <= r_acc - w_prod;
            S_NORM: begin
                r_k <= '0;
                if (w_zero) begin
                    r_step <= '0;
                end else if (!w_fits) begin
                    r_re <= r_re >>> 1;
                    r_im <= r_im >>> 1;
                end else if (w_re_c[CORDIC_W-1]) begin
                    // left half plane: fold by half a turn
                    r_x <= -w_re_c;
                    r_y <= -w_im_c;
                    r_z <= w_im_c[CORDIC_W-1] ? -(34'sd1 <<< 31) : (34'sd1 <<< 31);
                end else begin
                    r_x <= w_re_c;
                    r_y <= w_im_c;
                    r_z <= '0;
                end
            end
            S_VEC: begin
                r_x <= n_x;
                r_y <= n_y;
                r_z <= n_z;
                r_k <= r_k + 5'd1;
                if (w_vec_last) begin
                    r_step <= 18'((n_z + 34'sd32768) >>> 16);
                end
            end
            S_GAIN: if (w_mul_done) r_acc <= w_prod;
            S_DONE: begin
                if (w_out_free) begin
                    r_gray     <= w_gray;
                    r_out_weak <= r_weak;
                    r_out_last <= r_last;
                end
            end
            default: ;
        endcase
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.gray     = r_gray;
    assign o_out.weak_res = r_out_weak;
    assign o_out.out_last = r_out_last;

endmodule

// ----- design/fqgd_chk.sv -----
// Port-level checker of the demodulator and its bind to the top level.
`timescale 1ns / 1ps
module fqgd_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_gray,
    input logic       i_weak
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // a weak result is always white
    a_weak_white: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_weak |-> i_gray == 8'hFF)
        else $error("weak result not white");

    // one request in work at a time
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("new request taken while busy");

endmodule

bind fm_quadrature_gray_demodulator_unit fqgd_chk u_fqgd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_gray      (o_out.gray),
    .i_weak      (o_out.weak_res)
);

// ----- verif/tb_fm_quadrature_gray_demodulator_unit.sv -----
// Self-checking testbench of the FM gray demodulator: scoreboard predictor plus handshake drivers.
`timescale 1ns / 1ps
module tb_fm_quadrature_gray_demodulator_unit;
    import fqgd_pkg::*;

    // Expected gray result of one sample
    typedef struct {
        logic [7:0] gray;
        logic       is_weak;
        logic       last;
    } t_pixel;

    // Scoreboard: demodulator predictor and queue of expected pixels
    class gray_scoreboard;
        logic [31:0] step_reg;
        logic [15:0] gain_reg;
        logic [31:0] clip_reg;
        logic [31:0] phase_acc;
        longint      i_hist [FILTER_TAPS];
        longint      q_hist [FILTER_TAPS];
        int          hist_ptr;
        longint      i_sum;
        longint      q_sum;
        longint      last_i;
        longint      last_q;
        t_pixel      pending [$];
        int          mismatches;
        int          checked;
        int          weak_seen;

        function void clear();
            step_reg  = PHASE_STEP_RST;
            gain_reg  = GRAY_GAIN_RST;
            clip_reg  = CLIP_LEVEL_RST;
            phase_acc = '0;
            foreach (i_hist[k]) begin
                i_hist[k] = 0;
                q_hist[k] = 0;
            end
            hist_ptr   = 0;
            i_sum      = 0;
            q_sum      = 0;
            last_i     = 0;
            last_q     = 0;
            mismatches = 0;
            checked    = 0;
            weak_seen  = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                CFG_PHASE_STEP: step_reg = val;
                CFG_GRAY_GAIN:  gain_reg = val[15:0];
                CFG_CLIP_LEVEL: clip_reg = val;
                default: ;
            endcase
        endfunction

        // Round half up from Q30 and saturate to Q1.15
        function longint q15(longint v);
            longint r;
            r = (v + 16384) >>> 15;
            if (r > 32767) r = 32767;
            if (r < -32768) r = -32768;
            return r;
        endfunction

        // Carrier lookup: cosine and sine of the table entry at this phase
        function void carrier_lookup(logic [31:0] ph, output longint c, output longint s);
            logic [31:0] ang;
            longint      z, x, y, nx, ny;
            ang = {ph[31:22], 22'd0};
            z = longint'(ang[29:0]);
            x = 652032874;
            y = 0;
            for (int k = 0; k < ATAN_ENTRIES; k++) begin
                if (z >= 0) begin
                    nx = x - (y >>> k); ny = y + (x >>> k); z -= longint'(atan_turn(5'(k)));
                end else begin
                    nx = x + (y >>> k); ny = y - (x >>> k); z += longint'(atan_turn(5'(k)));
                end
                x = nx; y = ny;
            end
            case (ang[31:30])
                2'd0: begin c = q15(x);  s = q15(y);  end
                2'd1: begin c = q15(-y); s = q15(x);  end
                2'd2: begin c = q15(-x); s = q15(-y); end
                default: begin c = q15(y); s = q15(-x); end
            endcase
        endfunction

        // Vectoring CORDIC angle in 2^-16 turn
        function longint phase_angle(longint x, longint y);
            longint z, nx, ny, lim;
            z = 0;
            lim = longint'(1) << 30;
            if (x == 0 && y == 0) return 0;
            while (x >= lim || x < -lim || y >= lim || y < -lim) begin
                x = x >>> 1;
                y = y >>> 1;
            end
            if (x < 0) begin
                z = (y >= 0) ? (longint'(1) << 31) : -(longint'(1) << 31);
                x = -x;
                y = -y;
            end
            for (int k = 0; k < CORDIC_STAGES_DEF; k++) begin
                if (y >= 0) begin
                    nx = x + (y >>> k); ny = y - (x >>> k); z += longint'(atan_turn(5'(k)));
                end else begin
                    nx = x - (y >>> k); ny = y + (x >>> k); z -= longint'(atan_turn(5'(k)));
                end
                x = nx; y = ny;
            end
            return (z + 32768) >>> 16;
        endfunction

        function void note_sample(logic signed [15:0] smp, logic lst);
            longint c, s, mi, mq, fi, fq, stp, n;
            logic [63:0] cur_sq, prv_sq;
            t_pixel px;
            carrier_lookup(phase_acc, c, s);
            phase_acc += step_reg;
            mi = longint'(smp) * c;
            mq = longint'(smp) * s;
            i_sum += mi - i_hist[hist_ptr];
            q_sum += mq - q_hist[hist_ptr];
            i_hist[hist_ptr] = mi;
            q_hist[hist_ptr] = mq;
            hist_ptr = (hist_ptr + 1) % FILTER_TAPS;
            fi = i_sum / FILTER_TAPS;
            fq = q_sum / FILTER_TAPS;
            cur_sq = (64'(fi * fi) + 64'(fq * fq)) >> 14;
            prv_sq = (64'(last_i * last_i) + 64'(last_q * last_q)) >> 14;
            px.is_weak = (cur_sq <= clip_reg) && (prv_sq <= clip_reg);
            if (px.is_weak) begin
                px.gray = 8'd255;
            end else begin
                stp = phase_angle(last_i * fi + last_q * fq, last_i * fq - last_q * fi);
                n = 8355840 - longint'(gain_reg) * stp;
                if (n < 0) begin
                    px.gray = 8'd0;
                end else begin
                    n = (n + 32768) >>> 16;
                    px.gray = (n > 255) ? 8'd255 : n[7:0];
                end
            end
            last_i = fi;
            last_q = fq;
            px.last = lst;
            pending.push_back(px);
        endfunction

        function void check_pixel(logic [7:0] g, logic w, logic l);
            t_pixel px;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected pixel gray=%0d weak=%0b", g, w);
                return;
            end
            px = pending.pop_front();
            if (w) weak_seen++;
            if (px.gray !== g || px.is_weak !== w || px.last !== l) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("pixel %0d: exp gray=%0d weak=%0b last=%0b got %0d %0b %0b",
                             checked, px.gray, px.is_weak, px.last, g, w, l);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    gray_scoreboard sb;
    bit  hold_start = 1'b0;
    bit  hold_on = 1'b0;
    bit  no_idle = 1'b0;
    int  samples_sent = 0;

    fqgd_in_if  smp_if ();
    fqgd_out_if pix_if ();
    fqgd_cfg_if cfg_if ();

    fm_quadrature_gray_demodulator_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (smp_if.sink),
        .o_out   (pix_if.source),
        .i_cfg   (cfg_if.sink)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        smp_if.valid = 1'b0;
        smp_if.sample = '0;
        smp_if.block_last = 1'b0;
        pix_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_PHASE_STEP;
        cfg_if.data = '0;
    end

    // Long receiver hold-off, counted in cycles here
    initial begin
        wait (hold_start);
        @(posedge i_clk);
        hold_on = 1'b1;
        repeat (800) @(posedge i_clk);
        hold_on = 1'b0;
    end

    // Pixel sink: random stalls, long hold-off on request, checks each pixel
    always @(posedge i_clk) begin
        if (i_rst_n && pix_if.valid && pix_if.ready)
            sb.check_pixel(pix_if.gray, pix_if.weak_res, pix_if.out_last);
        if (hold_on) begin
            pix_if.ready <= 1'b0;
        end else begin
            pix_if.ready <= no_idle || ($urandom_range(99) >= 24);
        end
    end

    task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.write_reg(idx, val);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offer one sample, with a random gap before it unless no_idle is set
    task automatic send_sample(logic signed [15:0] smp, logic lst);
        while (!no_idle && $urandom_range(99) < 24) begin
            smp_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        smp_if.valid      <= 1'b1;
        smp_if.sample     <= smp;
        smp_if.block_last <= lst;
        do @(posedge i_clk); while (!smp_if.ready);
        sb.note_sample(smp, lst);
        samples_sent++;
    endtask

    task automatic drain();
        smp_if.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // Random tone-like burst: mostly a square-wave swing of +/-amp, sometimes noise
    task automatic send_burst(int n, int amp);
        int ph;
        int v;
        ph = $urandom_range(255);
        for (int k = 0; k < n; k++) begin
            ph = (ph + $urandom_range(40, 8)) % 256;
            if ($urandom_range(9) == 0)
                v = $signed(16'($urandom));
            else
                v = (ph < 128) ? amp : -amp;
            send_sample(16'(v), ($urandom_range(15) == 0));
        end
    endtask

    initial begin
        sb = new();
        sb.clear();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, silence (weak), zero vector, half-turn flips
        for (int k = 0; k < 6; k++) send_sample(16'sh0000, 1'b0);
        for (int k = 0; k < 4; k++) send_sample(16'sh7FFF, k[0]);
        for (int k = 0; k < 4; k++) send_sample(16'sh8000, 1'b1);
        for (int k = 0; k < 4; k++) send_sample(k[0] ? 16'sh7FFF : 16'sh8000, 1'b0);
        drain();
        // Zero carrier step: the carrier phase stays fixed, sign flips give a half turn
        cfg_write(CFG_PHASE_STEP, 32'd0);
        cfg_write(CFG_CLIP_LEVEL, 32'd0);
        for (int k = 0; k < 20; k++) send_sample(k < 8 ? 16'sh4000 : -16'sh4000, 1'b0);
        drain();

        // Random phases over several register settings, extremes included
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    cfg_write(CFG_PHASE_STEP, 32'hFFFF_FFFF);
                    cfg_write(CFG_GRAY_GAIN, 32'h0000_FFFF);
                    cfg_write(CFG_CLIP_LEVEL, 32'hFFFF_FFFF);
                end
                1: begin
                    cfg_write(CFG_PHASE_STEP, PHASE_STEP_RST);
                    cfg_write(CFG_GRAY_GAIN, 32'd0);
                    cfg_write(CFG_CLIP_LEVEL, 32'd0);
                end
                2: begin
                    cfg_write(CFG_GRAY_GAIN, {16'd0, GRAY_GAIN_RST});
                    cfg_write(CFG_CLIP_LEVEL, CLIP_LEVEL_RST);
                end
                default: begin
                    cfg_write(CFG_PHASE_STEP, $urandom);
                    cfg_write(CFG_GRAY_GAIN, $urandom);
                    cfg_write(CFG_CLIP_LEVEL, $urandom_range(4000000));
                end
            endcase
            if (ph == 3) no_idle = 1'b1;
            if (ph == 5) hold_start = 1'b1;
            send_burst(133, $urandom_range(32767, 64));
            no_idle = 1'b0;
            drain();
        end

        $display("tb: %0d samples over directed and 8 random register settings, %0d weak",
                 samples_sent, sb.weak_seen);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: %0d mismatches, %0d left", sb.mismatches, sb.pending.size());
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #12ms;
        $display("tb: failure");
        $finish;
    end
endmodule

// ----- sim.f -----
design/fqgd_pkg.sv
design/fqgd_if.sv
design/fqgd_mul.sv
design/fm_quadrature_gray_demodulator_unit.sv
design/fqgd_chk.sv
verif/tb_fm_quadrature_gray_demodulator_unit.sv
